FILE: src/gpio_controller_glitch_filter_macros.svh
// ----------------------------------------------------------------------------
// GPIO controller assertion macros
// Shared assertion forms for the GPIO controller checker.
// ----------------------------------------------------------------------------
`ifndef GPIO_CONTROLLER_GLITCH_FILTER_MACROS_SVH
`define GPIO_CONTROLLER_GLITCH_FILTER_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define GPIOGF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked during reset as well.
`define GPIOGF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/gpiogf_pkg.sv
// ----------------------------------------------------------------------------
// GPIO controller package
// Request layout, operation codes and register word offsets.
// ----------------------------------------------------------------------------
package gpiogf_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PIN   = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  localparam logic [1:0] LVL_LOW  = 2'd0;
  localparam logic [1:0] LVL_HIGH = 2'd1;

  typedef struct packed {
    logic [1:0]  pin_level;
    logic [4:0]  pin;
    logic [31:0] write_data;
    logic [6:0]  offset;
    op_t         op;
  } item_t;

  localparam int unsigned ITEM_BITS = $bits(item_t);
  localparam int unsigned OUT_BITS  = 72;

  localparam logic [6:0] OFS_OWN_SET  = 7'd0;
  localparam logic [6:0] OFS_OWN_CLR  = 7'd1;
  localparam logic [6:0] OFS_OWN_STAT = 7'd2;
  localparam logic [6:0] OFS_OE_SET   = 7'd4;
  localparam logic [6:0] OFS_OE_CLR   = 7'd5;
  localparam logic [6:0] OFS_OE_STAT  = 7'd6;
  localparam logic [6:0] OFS_FLT_SET  = 7'd8;
  localparam logic [6:0] OFS_FLT_CLR  = 7'd9;
  localparam logic [6:0] OFS_FLT_STAT = 7'd10;
  localparam logic [6:0] OFS_OD_SET   = 7'd12;
  localparam logic [6:0] OFS_OD_CLR   = 7'd13;
  localparam logic [6:0] OFS_OD_DATA  = 7'd14;
  localparam logic [6:0] OFS_PIN_STAT = 7'd15;
  localparam logic [6:0] OFS_IM_SET   = 7'd16;
  localparam logic [6:0] OFS_IM_CLR   = 7'd17;
  localparam logic [6:0] OFS_IM_STAT  = 7'd18;
  localparam logic [6:0] OFS_CHG_STAT = 7'd19;
  localparam logic [6:0] OFS_MD_SET   = 7'd20;
  localparam logic [6:0] OFS_MD_CLR   = 7'd21;
  localparam logic [6:0] OFS_MD_STAT  = 7'd22;
  localparam logic [6:0] OFS_PU_CLR   = 7'd24;
  localparam logic [6:0] OFS_PU_SET   = 7'd25;
  localparam logic [6:0] OFS_PU_STAT  = 7'd26;
  localparam logic [6:0] OFS_AB_CLR   = 7'd28;
  localparam logic [6:0] OFS_AB_SET   = 7'd29;
  localparam logic [6:0] OFS_AB_STAT  = 7'd30;
  localparam logic [6:0] OFS_WM_SET   = 7'd40;
  localparam logic [6:0] OFS_WM_CLR   = 7'd41;
  localparam logic [6:0] OFS_WM_STAT  = 7'd42;

endpackage

FILE: src/gpio_controller_glitch_filter.sv
// ----------------------------------------------------------------------------
// GPIO controller with glitch filters and input change interrupt
// Set/clear control registers, pad resolution, per-pin glitch filters and a
// latched change status, one request handled per clock while out_tready is high.
// ----------------------------------------------------------------------------
// Data path: an accepted request is held in the input register and its result
// is then registered into the result register that drives out_tdata.
// Throughput: one request per cycle while out_tready is high, with no gaps;
// when it is low the input and result registers fill and in_tready follows out_tready.
// Reset: synchronous rst_n empties both registers, restores all control
// registers to their defaults and sets the filter period to one tick.
module gpio_controller_glitch_filter #(
  parameter int PIN_COUNT  = 32,
  parameter int COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // offset[6:0], write_data[38:7], pin[43:39], pin_level[45:44], zero fill[47:46]
  input  logic [47:0] in_tdata,
  // op[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[31:0], pin_out[63:32], irq[64], zero fill[71:65]
  output logic [71:0] out_tdata,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  typedef logic [PIN_COUNT-1:0]  pins_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam pins_t ALL_PINS = '1;

  function automatic pins_t pad_f(pins_t own, pins_t oe, pins_t od, pins_t odat,
                                  pins_t pu, pins_t edrv, pins_t elvl);
    pins_t ext;
    pins_t pio_out;
    pins_t pp;
    pins_t od_low;
    ext     = (edrv & elvl) | (~edrv & pu);
    pio_out = own & oe;
    pp      = pio_out & ~od;
    od_low  = pio_out & od & ~odat;
    return (ext & ~(pp | od_low)) | (odat & pp);
  endfunction

  logic [7:0]         period_r;
  logic               iv_r;
  gpiogf_pkg::item_t  item_r;
  logic               ov_r;
  logic [71:0]        out_r;
  logic               advance;

  pins_t own_r, oe_r, odat_r, fe_r, od_r, pu_r, absel_r, wmask_r, imask_r;
  pins_t chg_r, elvl_r, edrv_r, acc_r, busy_r, goal_r, prev_r;
  cnt_t  cnt_r [PIN_COUNT];

  pins_t own_nxt, oe_nxt, odat_nxt, fe_nxt, od_nxt, pu_nxt, absel_nxt, wmask_nxt;
  pins_t imask_nxt, chg_nxt, elvl_nxt, edrv_nxt, acc_nxt, busy_nxt, goal_nxt;
  pins_t prev_nxt;
  cnt_t  cnt_nxt [PIN_COUNT];

  pins_t chg_a, acc_a, busy_a;
  cnt_t  cnt_a [PIN_COUNT];
  pins_t v, pad_pre, fresh, sel, expire, keep;
  pins_t pad, diff, busy1, restart, stat;
  logic  do_ref;
  logic [31:0] rd;
  logic [31:0] pin_out;
  logic  irq;
  cnt_t  load;
  logic [COUNT_BITS+7:0] period_ext;

  assign advance   = iv_r && (!ov_r || out_tready);
  assign in_tready = !iv_r || advance;
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  always_comb begin
    period_ext = {{COUNT_BITS{1'b0}}, period_r};
    if (period_r == 8'd0) begin
      load = cnt_t'(1);
    end else if (period_ext > {8'h00, {COUNT_BITS{1'b1}}}) begin
      load = '1;
    end else begin
      load = period_ext[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    v       = item_r.write_data[PIN_COUNT-1:0];
    pad_pre = pad_f(own_r, oe_r, od_r, odat_r, pu_r, edrv_r, elvl_r);
    own_nxt   = own_r;
    oe_nxt    = oe_r;
    odat_nxt  = odat_r;
    fe_nxt    = fe_r;
    od_nxt    = od_r;
    pu_nxt    = pu_r;
    absel_nxt = absel_r;
    wmask_nxt = wmask_r;
    imask_nxt = imask_r;
    elvl_nxt  = elvl_r;
    edrv_nxt  = edrv_r;
    goal_nxt  = goal_r;
    chg_a     = chg_r;
    acc_a     = acc_r;
    busy_a    = busy_r;
    cnt_a     = cnt_r;
    fresh     = '0;
    sel       = '0;
    expire    = '0;
    keep      = '0;
    rd        = '0;
    do_ref    = 1'b0;
    for (int n = 0; n < PIN_COUNT; n++) begin
      sel[n] = (item_r.pin == 5'(n));
    end
    unique case (item_r.op)
      gpiogf_pkg::OP_WRITE: begin
        do_ref = 1'b1;
        unique case (item_r.offset)
          gpiogf_pkg::OFS_OWN_SET: own_nxt = own_r | v;
          gpiogf_pkg::OFS_OWN_CLR: own_nxt = own_r & ~v;
          gpiogf_pkg::OFS_OE_SET:  oe_nxt = oe_r | v;
          gpiogf_pkg::OFS_OE_CLR:  oe_nxt = oe_r & ~v;
          gpiogf_pkg::OFS_FLT_SET: begin
            fresh  = v & ~fe_r;
            acc_a  = (acc_r & ~fresh) | (pad_pre & fresh);
            busy_a = busy_r & ~fresh;
            fe_nxt = fe_r | v;
          end
          gpiogf_pkg::OFS_FLT_CLR: begin
            fe_nxt = fe_r & ~v;
            busy_a = busy_r & ~v;
          end
          gpiogf_pkg::OFS_OD_SET:  odat_nxt = odat_r | v;
          gpiogf_pkg::OFS_OD_CLR:  odat_nxt = odat_r & ~v;
          gpiogf_pkg::OFS_OD_DATA: odat_nxt = (odat_r & ~wmask_r) | (v & wmask_r);
          gpiogf_pkg::OFS_IM_SET:  imask_nxt = imask_r | v;
          gpiogf_pkg::OFS_IM_CLR:  imask_nxt = imask_r & ~v;
          gpiogf_pkg::OFS_MD_SET:  od_nxt = od_r | v;
          gpiogf_pkg::OFS_MD_CLR:  od_nxt = od_r & ~v;
          gpiogf_pkg::OFS_PU_CLR:  pu_nxt = pu_r & ~v;
          gpiogf_pkg::OFS_PU_SET:  pu_nxt = pu_r | v;
          gpiogf_pkg::OFS_AB_CLR: begin
            absel_nxt = absel_r & ~v;
            do_ref    = 1'b0;
          end
          gpiogf_pkg::OFS_AB_SET: begin
            absel_nxt = absel_r | v;
            do_ref    = 1'b0;
          end
          gpiogf_pkg::OFS_WM_SET: begin
            wmask_nxt = wmask_r | v;
            do_ref    = 1'b0;
          end
          gpiogf_pkg::OFS_WM_CLR: begin
            wmask_nxt = wmask_r & ~v;
            do_ref    = 1'b0;
          end
          default: do_ref = 1'b0;
        endcase
      end
      gpiogf_pkg::OP_READ: begin
        unique case (item_r.offset)
          gpiogf_pkg::OFS_OWN_STAT: rd = 32'(own_r);
          gpiogf_pkg::OFS_OE_STAT:  rd = 32'(oe_r);
          gpiogf_pkg::OFS_FLT_STAT: rd = 32'(fe_r);
          gpiogf_pkg::OFS_OD_DATA:  rd = 32'(odat_r);
          gpiogf_pkg::OFS_PIN_STAT: rd = 32'((pad_pre & ~fe_r) | (acc_r & fe_r));
          gpiogf_pkg::OFS_IM_STAT:  rd = 32'(imask_r);
          gpiogf_pkg::OFS_CHG_STAT: begin
            rd    = 32'(chg_r);
            chg_a = '0;
          end
          gpiogf_pkg::OFS_MD_STAT:  rd = 32'(od_r);
          gpiogf_pkg::OFS_PU_STAT:  rd = 32'(~pu_r & ALL_PINS);
          gpiogf_pkg::OFS_AB_STAT:  rd = 32'(absel_r);
          gpiogf_pkg::OFS_WM_STAT:  rd = 32'(wmask_r);
          default:                  rd = '0;
        endcase
      end
      gpiogf_pkg::OP_PIN: begin
        do_ref = |sel;
        unique case (item_r.pin_level)
          gpiogf_pkg::LVL_LOW: begin
            edrv_nxt = edrv_r | sel;
            elvl_nxt = elvl_r & ~sel;
          end
          gpiogf_pkg::LVL_HIGH: begin
            edrv_nxt = edrv_r | sel;
            elvl_nxt = elvl_r | sel;
          end
          default: edrv_nxt = edrv_r & ~sel;
        endcase
      end
      gpiogf_pkg::OP_TICK: begin
        for (int n = 0; n < PIN_COUNT; n++) begin
          if (busy_r[n]) begin
            if (cnt_r[n] > cnt_t'(1)) begin
              cnt_a[n] = cnt_r[n] - cnt_t'(1);
            end else begin
              cnt_a[n]  = '0;
              expire[n] = 1'b1;
            end
          end
        end
        keep   = expire & ~(pad_pre ^ goal_r);
        acc_a  = (acc_r & ~keep) | (goal_r & keep);
        busy_a = busy_r & ~expire;
        do_ref = |expire;
      end
      default: rd = '0;
    endcase

    pad     = pad_f(own_nxt, oe_nxt, od_nxt, odat_nxt, pu_nxt, edrv_nxt, elvl_nxt);
    diff    = fe_nxt & (pad ^ acc_a);
    busy1   = busy_a & diff;
    restart = diff & (~busy1 | (goal_r ^ pad));
    stat    = (pad & ~fe_nxt) | (acc_a & fe_nxt);
    acc_nxt = acc_a;
    if (do_ref) begin
      busy_nxt = busy1 | restart;
      goal_nxt = (goal_r & ~restart) | (pad & restart);
      chg_nxt  = chg_a | (stat ^ prev_r);
      prev_nxt = stat;
      for (int n = 0; n < PIN_COUNT; n++) begin
        cnt_nxt[n] = restart[n] ? load : cnt_a[n];
      end
    end else begin
      busy_nxt = busy_a;
      chg_nxt  = chg_a;
      prev_nxt = prev_r;
      cnt_nxt  = cnt_a;
    end
    pin_out = 32'(pad & own_nxt & oe_nxt);
    irq     = |(chg_nxt & imask_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 8'd1;
    end else if (cfg_we) begin
      period_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        iv_r <= 1'b1;
      end else if (advance) begin
        iv_r <= 1'b0;
      end
      if (advance) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= gpiogf_pkg::item_t'({in_tdata[45:0], in_tuser});
    end
    if (advance) begin
      out_r <= {7'd0, irq, pin_out, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r   <= ALL_PINS;
      oe_r    <= '0;
      odat_r  <= '0;
      fe_r    <= '0;
      od_r    <= '0;
      pu_r    <= ALL_PINS;
      absel_r <= '0;
      wmask_r <= '0;
      imask_r <= '0;
      chg_r   <= '0;
      elvl_r  <= '0;
      edrv_r  <= '0;
      acc_r   <= ALL_PINS;
      busy_r  <= '0;
      goal_r  <= '0;
      prev_r  <= ALL_PINS;
      for (int n = 0; n < PIN_COUNT; n++) begin
        cnt_r[n] <= '0;
      end
    end else if (advance) begin
      own_r   <= own_nxt;
      oe_r    <= oe_nxt;
      odat_r  <= odat_nxt;
      fe_r    <= fe_nxt;
      od_r    <= od_nxt;
      pu_r    <= pu_nxt;
      absel_r <= absel_nxt;
      wmask_r <= wmask_nxt;
      imask_r <= imask_nxt;
      chg_r   <= chg_nxt;
      elvl_r  <= elvl_nxt;
      edrv_r  <= edrv_nxt;
      acc_r   <= acc_nxt;
      busy_r  <= busy_nxt;
      goal_r  <= goal_nxt;
      prev_r  <= prev_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: src/gpiogf_checker.sv
// ----------------------------------------------------------------------------
// GPIO controller port checker
// Checks reset, stall, rate and zero fill behavior seen on the controller's ports.
// ----------------------------------------------------------------------------
`include "gpio_controller_glitch_filter_macros.svh"

module gpiogf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  `GPIOGF_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result after reset")
  `GPIOGF_ASSERT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `GPIOGF_ASSERT(a_ready_flow, clk, rst_n, out_tready |-> in_tready, "request blocked while results drain")
  `GPIOGF_ASSERT(a_latency, clk, rst_n, in_tvalid && in_tready ##1 out_tready |=> out_tvalid, "result late")
  `GPIOGF_ASSERT(a_fill_zero, clk, rst_n, out_tvalid |-> out_tdata[71:65] == 7'd0, "fill bits set")

endmodule

bind gpio_controller_glitch_filter gpiogf_checker u_gpiogf_checker (.*);
